FILE: design/assert_macros.svh
// assertion helpers used by oli_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define OLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define OLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg
// Types and constants of the ordered list with insert and delete.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // what a cell loads at the next edge
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_PREV,
        OP_NEXT,
        OP_HEAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic signed [VAL_W-1:0] data;
    } t_cell_ctl;

endpackage

FILE: design/oli_if.sv
// ----------------------------------------------------------------------------
// oli_req_if / oli_rsp_if
// Valid/ready channels for requests and results of the ordered list.
// ----------------------------------------------------------------------------
interface oli_req_if
    import oli_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

interface oli_rsp_if
    import oli_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic [IDX_W-1:0]        entry_index;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;

    modport source (output valid, output status, output entry_value,
                    output entry_index, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value,
                    input entry_index, input entry_count, input last,
                    output ready);
endinterface

FILE: design/oli_cell.sv
// ----------------------------------------------------------------------------
// oli_cell
// One list slot: holds an entry, compares it with the search key and takes
// a value from itself, the key, a neighbor or the list head.
// ----------------------------------------------------------------------------
module oli_cell
    import oli_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_prev,
    input  logic signed [VAL_W-1:0] i_next,
    input  logic signed [VAL_W-1:0] i_head,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_match
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    always_comb begin
        case (i_ctl.op)
            OP_LOAD: n_value = i_ctl.data;
            OP_PREV: n_value = i_prev;
            OP_NEXT: n_value = i_next;
            OP_HEAD: n_value = i_head;
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_ctl.data);

endmodule

FILE: design/oli_ctrl.sv
// ----------------------------------------------------------------------------
// oli_ctrl
// Request sequencer: keeps the entry count, steers the cell row and drives
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oli_ctrl
    import oli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    oli_req_if.sink                 i_req,
    oli_rsp_if.source               o_rsp,
    input  logic signed [VAL_W-1:0] i_cell_val   [CAPACITY],
    input  logic                    i_cell_match [CAPACITY],
    output t_cell_ctl               o_cell_ctl   [CAPACITY]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_dump_idx, n_dump_idx;
    logic [1:0]              r_kind, n_kind;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_o_valid, n_o_valid;
    t_status                 r_o_status, n_o_status;
    logic signed [VAL_W-1:0] r_o_value, n_o_value;
    logic [IDX_W-1:0]        r_o_index, n_o_index;
    logic [CNT_W-1:0]        r_o_count, n_o_count;
    logic                    r_o_last, n_o_last;

    logic                    out_free;
    logic                    in_xfer;
    logic [CW-1:0]           pos_eff;
    logic [CAPACITY-1:0]     match_v;
    logic [CAPACITY-1:0]     after_match;
    logic [IW-1:0]           first_idx;

    assign out_free = !r_o_valid || o_rsp.ready;
    assign in_xfer  = i_req.valid && i_req.ready;

    assign pos_eff = (CMPW'(r_pos) > CMPW'(r_count)) ? r_count : CW'(r_pos);

    // occupied cells holding the key, prefix from the front, first hit
    always_comb begin
        logic acc;
        acc       = 1'b0;
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match_v[i]     = i_cell_match[i] && (CW'(i) < r_count);
            acc            = acc | match_v[i];
            after_match[i] = acc;
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match_v[i]) begin
                first_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dump_idx = r_dump_idx;
        n_kind     = r_kind;
        n_key      = r_key;
        n_pos      = r_pos;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_index  = r_o_index;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        for (int i = 0; i < CAPACITY; i++) begin
            o_cell_ctl[i].op   = OP_HOLD;
            o_cell_ctl[i].data = r_key;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_kind = i_req.req_type;
                    n_key  = i_req.value;
                    n_pos  = i_req.position;
                    // unused request code gives no result
                    if (i_req.req_type inside {REQ_INSERT, REQ_DELETE, REQ_DUMP}) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_value = '0;
                    n_o_last  = 1'b1;
                    n_o_index = '0;
                    n_state   = S_IDLE;
                    case (r_kind)
                        REQ_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_o_status = ST_FULL;
                                n_o_count  = CNT_W'(r_count);
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (CW'(i) == pos_eff) begin
                                        o_cell_ctl[i].op = OP_LOAD;
                                    end else if (CW'(i) > pos_eff && CW'(i) <= r_count) begin
                                        o_cell_ctl[i].op = OP_PREV;
                                    end
                                end
                                n_count    = r_count + CW'(1);
                                n_o_status = ST_OK;
                                n_o_index  = IDX_W'(pos_eff);
                                n_o_count  = CNT_W'(r_count + CW'(1));
                            end
                        end
                        REQ_DELETE: begin
                            if (|match_v) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (after_match[i]) begin
                                        o_cell_ctl[i].op = OP_NEXT;
                                    end
                                end
                                n_count    = r_count - CW'(1);
                                n_o_status = ST_OK;
                                n_o_index  = IDX_W'(first_idx);
                                n_o_count  = CNT_W'(r_count - CW'(1));
                            end else begin
                                n_o_status = ST_NOT_FOUND;
                                n_o_count  = CNT_W'(r_count);
                            end
                        end
                        REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_o_status = ST_EMPTY;
                                n_o_count  = '0;
                            end else begin
                                // no result yet, the stream is emitted from S_DUMP
                                n_o_valid  = r_o_valid && !o_rsp.ready;
                                n_o_last   = r_o_last;
                                n_o_index  = r_o_index;
                                n_o_value  = r_o_value;
                                n_dump_idx = '0;
                                n_state    = S_DUMP;
                            end
                        end
                        default: begin
                            n_o_valid = r_o_valid && !o_rsp.ready;
                            n_o_last  = r_o_last;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    // emit the head and rotate the occupied cells by one
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CW'(i) + CW'(1) < r_count) begin
                            o_cell_ctl[i].op = OP_NEXT;
                        end else if (CW'(i) + CW'(1) == r_count) begin
                            o_cell_ctl[i].op = OP_HEAD;
                        end
                    end
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_value  = i_cell_val[0];
                    n_o_index  = IDX_W'(r_dump_idx);
                    n_o_count  = CNT_W'(r_count);
                    n_o_last   = (r_dump_idx == r_count - CW'(1));
                    n_dump_idx = r_dump_idx + CW'(1);
                    if (r_dump_idx == r_count - CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_dump_idx <= n_dump_idx;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_index  <= n_o_index;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.entry_value = r_o_value;
    assign o_rsp.entry_index = r_o_index;
    assign o_rsp.entry_count = r_o_count;
    assign o_rsp.last        = r_o_last;

    `OLI_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `OLI_ASSERT(a_dump_range, (r_state != S_DUMP) || (r_dump_idx < r_count),
        "dump index past last entry")
    `OLI_ASSERT_NEXT(a_insert_grows,
        r_state == S_EXEC && r_kind == REQ_INSERT && out_free && r_count != CW'(CAPACITY),
        r_count == $past(r_count) + CW'(1), "insert did not grow the list")
    `OLI_ASSERT_NEXT(a_dump_keeps_count, r_state == S_DUMP, r_count == $past(r_count),
        "count changed during dump")

endmodule

FILE: design/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed 32-bit values with insert at position, delete of
// the first matching value and a dump of all entries.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells that all shift or compare in the
// same cycle. A request is registered in the idle state and executed in the
// execute state once the output register is free; the block then takes the
// next request while its result still sits in the output register. A dump
// rotates the cell row by one entry per transfer and the head cell feeds the
// result register; an empty dump, a full insert and a failed delete give one
// result. Results leave through a single output register, so a stalled
// consumer holds the execute and dump steps.
module ordered_list_insert_delete
    import oli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oli_req_if.sink   i_req,
    oli_rsp_if.source o_rsp
);

    logic signed [VAL_W-1:0] w_val   [CAPACITY];
    logic                    w_match [CAPACITY];
    t_cell_ctl               w_ctl   [CAPACITY];

    oli_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_cell_val   (w_val),
        .i_cell_match (w_match),
        .o_cell_ctl   (w_ctl)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] w_prev;
        logic signed [VAL_W-1:0] w_next;

        if (i == 0) begin : g_first
            assign w_prev = w_val[i];
        end else begin : g_mid
            assign w_prev = w_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign w_next = w_val[i];
        end else begin : g_inner
            assign w_next = w_val[i+1];
        end

        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[i]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_val[0]),
            .o_value (w_val[i]),
            .o_match (w_match[i])
        );
    end

endmodule
